>>> rtl/falt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falt_pkg
// Shared types and constants of the fully associative LRU TLB.
// ----------------------------------------------------------------------------
package falt_pkg;

    // configuration port
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_OFFSET    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 1'b1;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0] PAGE_OFFSET_RST    = 5'd12;
    localparam logic [CFG_W-1:0] ENTRIES_IN_USE_RST = 5'd16;

    // result field widths
    localparam int ADDR_W  = 32;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 32;

    // controller to datapath
    typedef struct packed {
        logic load;    // item accepted, capture page number
        logic look;    // search table, register the decision
        logic commit;  // update table and load the result register
    } falt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;  // result register can take a new item
    } falt_status_t;

endpackage

>>> rtl/falt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falt_ctrl
// Sequencer of the TLB: accept, lookup and commit phases of each item.
// ----------------------------------------------------------------------------
module falt_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  falt_pkg::falt_status_t status,
    output falt_pkg::falt_cmd_t    cmd
);
    import falt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       commit_ok;

    // commit needs room in the result register; the next item enters with it
    assign commit_ok  = (state_reg == ST_UPD) && status.out_free;
    assign s_ready    = (state_reg == ST_IDLE) || commit_ok;
    assign cmd.load   = s_valid && s_ready;
    assign cmd.look   = (state_reg == ST_LOOK);
    assign cmd.commit = commit_ok;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_LOOK;
            end
            ST_LOOK: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (status.out_free) state_next = s_valid ? ST_LOOK : ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/falt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falt_datapath
// Page table, parallel tag match, LRU ranks, miss counter, result register.
// ----------------------------------------------------------------------------
module falt_datapath #(
    parameter int ENTRIES   = 16,
    parameter int ADDR_BITS = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [falt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [falt_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic [falt_pkg::ADDR_W-1:0]        s_address,
    input  falt_pkg::falt_cmd_t                cmd,
    output falt_pkg::falt_status_t             status,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_hit,
    output logic [falt_pkg::SLOT_W-1:0]        m_slot,
    output logic [falt_pkg::COUNT_W-1:0]       m_miss_total
);
    import falt_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RW = IW;
    localparam int NW = ($clog2(ENTRIES + 1) > CFG_W) ? $clog2(ENTRIES + 1) : CFG_W;
    localparam logic [RW-1:0] RANK_MAX = RW'(ENTRIES - 1);

    // configuration
    logic [CFG_W-1:0] page_offset_reg;
    logic [CFG_W-1:0] in_use_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_offset_reg <= PAGE_OFFSET_RST;
            in_use_reg      <= ENTRIES_IN_USE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PAGE_OFFSET:    page_offset_reg <= cfg_wdata;
                CFG_ENTRIES_IN_USE: in_use_reg      <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // page number of the accepted item
    logic [ADDR_BITS-1:0] addr_ext;
    logic [ADDR_BITS-1:0] page_reg;

    generate
        if (ADDR_BITS <= ADDR_W) begin : g_addr_cut
            assign addr_ext = s_address[ADDR_BITS-1:0];
        end else begin : g_addr_ext
            assign addr_ext = {{(ADDR_BITS - ADDR_W){1'b0}}, s_address};
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (cmd.load) page_reg <= addr_ext >> page_offset_reg;
    end

    // table state
    logic                 valid_reg [ENTRIES];
    logic                 valid_next [ENTRIES];
    logic [ADDR_BITS-1:0] tag_reg [ENTRIES];
    logic [RW-1:0]        rank_reg [ENTRIES];
    logic [RW-1:0]        rank_next [ENTRIES];
    logic [COUNT_W-1:0]   miss_reg;
    logic [COUNT_W-1:0]   miss_next;

    // slots in use, zero taken as one and clamped to the table size
    logic [NW-1:0] n_used;
    logic          in_use [ENTRIES];

    always_comb begin
        n_used = NW'(in_use_reg);
        if (n_used == '0) n_used = NW'(1);
        if (n_used > NW'(ENTRIES)) n_used = NW'(ENTRIES);
    end

    // parallel match, free slot and oldest slot flags
    logic hit_vec [ENTRIES];
    logic free_vec [ENTRIES];
    logic old_vec [ENTRIES];

    always_comb begin
        for (int j = 0; j < ENTRIES; j++) begin
            in_use[j]   = NW'(j) < n_used;
            hit_vec[j]  = in_use[j] && valid_reg[j] && (tag_reg[j] == page_reg);
            free_vec[j] = in_use[j] && !valid_reg[j];
            // oldest: above every earlier slot, not below any later one
            old_vec[j]  = in_use[j];
            for (int k = 0; k < ENTRIES; k++) begin
                if (NW'(k) < n_used) begin
                    if (k < j && !(rank_reg[k] < rank_reg[j])) old_vec[j] = 1'b0;
                    if (k > j && (rank_reg[k] > rank_reg[j])) old_vec[j] = 1'b0;
                end
            end
        end
    end

    // lowest-numbered flagged slot of each kind
    logic          any_hit;
    logic          any_free;
    logic [IW-1:0] hit_idx;
    logic [IW-1:0] free_idx;
    logic [IW-1:0] old_idx;
    logic [IW-1:0] tgt_idx;

    always_comb begin
        any_hit  = 1'b0;
        any_free = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        old_idx  = '0;
        for (int j = ENTRIES - 1; j >= 0; j--) begin
            if (hit_vec[j]) begin
                any_hit = 1'b1;
                hit_idx = IW'(j);
            end
            if (free_vec[j]) begin
                any_free = 1'b1;
                free_idx = IW'(j);
            end
            if (old_vec[j]) old_idx = IW'(j);
        end
        if (any_hit)       tgt_idx = hit_idx;
        else if (any_free) tgt_idx = free_idx;
        else               tgt_idx = old_idx;
    end

    // registered decision of the lookup
    logic          hit_reg;
    logic          fill_reg;
    logic [IW-1:0] tgt_reg;
    logic [RW-1:0] tgt_rank_reg;

    always_ff @(posedge aclk) begin
        if (cmd.look) begin
            hit_reg      <= any_hit;
            fill_reg     <= !any_hit && any_free;
            tgt_reg      <= tgt_idx;
            tgt_rank_reg <= rank_reg[tgt_idx];
        end
    end

    // rank and valid update at commit
    always_comb begin
        for (int j = 0; j < ENTRIES; j++) begin
            valid_next[j] = valid_reg[j];
            rank_next[j]  = rank_reg[j];
            if (IW'(j) == tgt_reg) begin
                valid_next[j] = 1'b1;
                rank_next[j]  = '0;
            end else if (fill_reg) begin
                // fill ages every valid slot
                if (valid_reg[j] && rank_reg[j] < RANK_MAX) rank_next[j] = rank_reg[j] + 1'b1;
            end else begin
                // touch ages only the slots younger than the target
                if (valid_reg[j] && rank_reg[j] < tgt_rank_reg)
                    rank_next[j] = rank_reg[j] + 1'b1;
            end
        end
    end

    // saturating miss counter
    always_comb begin
        miss_next = miss_reg;
        if (!hit_reg && miss_reg != {COUNT_W{1'b1}}) miss_next = miss_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < ENTRIES; j++) begin
                valid_reg[j] <= 1'b0;
                rank_reg[j]  <= '0;
            end
            miss_reg <= '0;
        end else if (cmd.commit) begin
            for (int j = 0; j < ENTRIES; j++) begin
                valid_reg[j] <= valid_next[j];
                rank_reg[j]  <= rank_next[j];
            end
            miss_reg <= miss_next;
        end
    end

    // page write on a miss
    always_ff @(posedge aclk) begin
        if (cmd.commit && !hit_reg) tag_reg[tgt_reg] <= page_reg;
    end

    // result register
    logic                 m_valid_reg;
    logic                 m_hit_reg;
    logic [SLOT_W-1:0]    m_slot_reg;
    logic [COUNT_W-1:0]   m_miss_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_hit_reg  <= hit_reg;
            m_slot_reg <= SLOT_W'(tgt_reg);
            m_miss_reg <= miss_next;
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_hit           = m_hit_reg;
    assign m_slot          = m_slot_reg;
    assign m_miss_total    = m_miss_reg;

endmodule

>>> rtl/fully_assoc_lru_tlb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fully_assoc_lru_tlb
// Fully associative TLB with true-LRU replacement, one result per address.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_address carry one memory address per item. Each item
//   gives one result item on m_valid/m_ready: m_hit, m_slot (matched or
//   filled slot) and m_miss_total (saturating miss count after this item).
//   cfg_we/cfg_index/cfg_wdata write page_offset_bits (index 0) and
//   entries_in_use (index 1); write only while no item is in flight.
//   After acceptance an item passes the lookup state and then the table
//   update state, where it is committed once the result register has room;
//   the next item is taken in that update state, together with the commit.
//   The tag match over all slots and the LRU rank update are parallel.
//   Reset clears valid marks, ranks, miss count and the result register;
//   configuration returns to 12 offset bits and 16 slots in use.
//   A stalled receiver holds the result; one more item is taken and looked
//   up, then s_ready stays low until the result register drains.
// ----------------------------------------------------------------------------
module fully_assoc_lru_tlb #(
    parameter int ENTRIES   = 16,
    parameter int ADDR_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [falt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [falt_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [falt_pkg::ADDR_W-1:0]    s_address,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_hit,
    output logic [falt_pkg::SLOT_W-1:0]    m_slot,
    output logic [falt_pkg::COUNT_W-1:0]   m_miss_total
);
    import falt_pkg::*;

    falt_cmd_t    cmd;
    falt_status_t status;

    // sequencer
    falt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // table and result path
    falt_datapath #(
        .ENTRIES   (ENTRIES),
        .ADDR_BITS (ADDR_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_address    (s_address),
        .cmd          (cmd),
        .status       (status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hit        (m_hit),
        .m_slot       (m_slot),
        .m_miss_total (m_miss_total)
    );

    // an accepted item is always looked up in the next cycle
    a_load_then_look: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> cmd.look)
        else $error("lookup did not follow an accepted item");

    // no item enters while a lookup is in progress
    a_no_accept_in_look: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.look |-> !s_ready)
        else $error("item accepted during lookup");

    // a commit never overwrites a result that is still waiting
    a_commit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid || m_ready))
        else $error("result register overwritten");

    // every commit presents a result
    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid)
        else $error("committed item not presented");

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fully associative LRU TLB. A short stimulus
// table covers the address extremes, shrinking, zero and oversized slot
// counts and the extreme page offsets. It is followed by random traces with
// hot page sets under several configurations. Each result item is checked
// against typed results or a local model of the table, its LRU ranks and the miss count.
// ----------------------------------------------------------------------------
module testbench;
    import falt_pkg::*;

    localparam int SLOTS          = 16;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_ITEMS   = 700;
    localparam int PHASES         = 8;
    localparam int DIR_LEN        = 26;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        logic                 hit;
        logic [SLOT_W-1:0]    slot;
        logic [COUNT_W-1:0]   misses;
    } tlb_result_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [ADDR_W-1:0]    value;
        logic                 known;
        tlb_result_t          want;
    } stim_row_t;

    localparam tlb_result_t NO_RES = '0;

    // directed rows: typed results only right after reset
    localparam stim_row_t DIR_ROWS [0:DIR_LEN-1] = '{
        '{ROW_ITEM, CFG_PAGE_OFFSET,    32'h0000_0000, 1'b1, '{1'b0, 4'd0, 32'd1}},
        '{ROW_ITEM, CFG_PAGE_OFFSET,    32'h0000_0FFF, 1'b1, '{1'b1, 4'd0, 32'd1}},
        '{ROW_ITEM, CFG_PAGE_OFFSET,    32'hFFFF_FFFF, 1'b1, '{1'b0, 4'd1, 32'd2}},
        '{ROW_ITEM, CFG_PAGE_OFFSET,    32'hFFFF_F000, 1'b1, '{1'b1, 4'd1, 32'd2}},
        '{ROW_ITEM, CFG_PAGE_OFFSET,    32'h0000_1000, 1'b1, '{1'b0, 4'd2, 32'd3}},
        '{ROW_CFG,  CFG_ENTRIES_IN_USE, 32'd2,         1'b0, NO_RES},
        '{ROW_ITEM, CFG_PAGE_OFFSET,    32'h0000_1000, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PAGE_OFFSET,    32'h0000_2000, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PAGE_OFFSET,    32'h0000_1FFF, 1'b0, NO_RES},
        '{ROW_CFG,  CFG_ENTRIES_IN_USE, 32'd0,         1'b0, NO_RES},
        '{ROW_ITEM, CFG_PAGE_OFFSET,    32'hFFFF_FFFF, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PAGE_OFFSET,    32'hFFFF_FFFF, 1'b0, NO_RES},
        '{ROW_CFG,  CFG_ENTRIES_IN_USE, 32'd31,        1'b0, NO_RES},
        '{ROW_ITEM, CFG_PAGE_OFFSET,    32'h0000_1000, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PAGE_OFFSET,    32'h0000_3000, 1'b0, NO_RES},
        '{ROW_CFG,  CFG_PAGE_OFFSET,    32'd0,         1'b0, NO_RES},
        '{ROW_ITEM, CFG_PAGE_OFFSET,    32'h0000_0000, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PAGE_OFFSET,    32'hFFFF_FFFF, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PAGE_OFFSET,    32'h8000_0000, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PAGE_OFFSET,    32'h0000_0001, 1'b0, NO_RES},
        '{ROW_CFG,  CFG_PAGE_OFFSET,    32'd31,        1'b0, NO_RES},
        '{ROW_ITEM, CFG_PAGE_OFFSET,    32'h7FFF_FFFF, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PAGE_OFFSET,    32'h8000_0000, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PAGE_OFFSET,    32'h0000_0000, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_PAGE_OFFSET,    32'hFFFF_FFFF, 1'b0, NO_RES},
        '{ROW_CFG,  CFG_ENTRIES_IN_USE, 32'd16,        1'b0, NO_RES}
    };

    // per-phase settings, the last phase is drawn at random
    localparam int PHASE_OFFSET  [0:PHASES-1] = '{12, 0, 31, 5, 20, 16, 3, 0};
    localparam int PHASE_ENTRIES [0:PHASES-1] = '{16, 1, 31, 4, 0, 9, 16, 0};

    // dut ports
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [ADDR_W-1:0]    s_address = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic                 m_hit;
    logic [SLOT_W-1:0]    m_slot;
    logic [COUNT_W-1:0]   m_miss_total;

    // model state of the table
    logic [CFG_W-1:0]   cur_offset  = PAGE_OFFSET_RST;
    logic [CFG_W-1:0]   cur_entries = ENTRIES_IN_USE_RST;
    bit                 slot_valid [SLOTS];
    logic [ADDR_W-1:0]  slot_page  [SLOTS];
    int unsigned        age_rank   [SLOTS];
    logic [COUNT_W-1:0] miss_count = '0;

    tlb_result_t pending_q [$];
    int          fail_count  = 0;
    int          idle_cycles = 0;
    bit          feeding     = 1'b0;
    int          stall_mode  = 0;
    int          stall_timer = 0;

    fully_assoc_lru_tlb dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_address    (s_address),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hit        (m_hit),
        .m_slot       (m_slot),
        .m_miss_total (m_miss_total)
    );

    always #1 aclk = ~aclk;

    // move a valid slot to rank zero, younger valid slots age by one
    function automatic void make_recent(int s);
        int unsigned r;
        r = age_rank[s];
        for (int j = 0; j < SLOTS; j++) begin
            if (j != s && slot_valid[j] && age_rank[j] < r) age_rank[j]++;
        end
        age_rank[s] = 0;
    endfunction

    // look up one address, update the table and return the result
    function automatic tlb_result_t lookup_address(logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] page;
        int                used;
        int                found;
        int                victim;
        tlb_result_t       res;
        page  = addr >> cur_offset;
        used  = (cur_entries == 0) ? 1 : ((cur_entries > SLOTS) ? SLOTS : int'(cur_entries));
        found = -1;
        for (int j = 0; j < used; j++) begin
            if (found < 0 && slot_valid[j] && slot_page[j] == page) found = j;
        end
        res.hit = (found >= 0);
        if (found >= 0) begin
            make_recent(found);
        end else begin
            if (miss_count != '1) miss_count++;
            for (int j = 0; j < used; j++) begin
                if (found < 0 && !slot_valid[j]) found = j;
            end
            if (found >= 0) begin
                // fill a free slot, every valid slot ages
                for (int j = 0; j < SLOTS; j++) begin
                    if (slot_valid[j] && age_rank[j] < SLOTS - 1) age_rank[j]++;
                end
                slot_valid[found] = 1'b1;
                slot_page[found]  = page;
                age_rank[found]   = 0;
            end else begin
                // evict the oldest slot in use, lowest index on ties
                victim = 0;
                for (int j = 1; j < used; j++) begin
                    if (age_rank[j] > age_rank[victim]) victim = j;
                end
                found            = victim;
                slot_page[found] = page;
                make_recent(found);
            end
        end
        res.slot   = SLOT_W'(found);
        res.misses = miss_count;
        return res;
    endfunction

    // present one item and wait for it to be taken
    task automatic send_address(logic [ADDR_W-1:0] addr, logic known, tlb_result_t typed);
        tlb_result_t predicted;
        s_valid   <= 1'b1;
        s_address <= addr;
        feeding    = 1'b1;
        do @(posedge aclk); while (!s_ready);
        predicted = lookup_address(addr);
        pending_q.push_back(known ? typed : predicted);
    endtask

    // drop valid and idle for a number of cycles
    task automatic pause_sender(int cycles);
        if (cycles > 0) begin
            if (feeding) begin
                s_valid <= 1'b0;
                feeding  = 1'b0;
            end
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // wait until every expected result has come, then let the block settle
    task automatic drain_results();
        if (feeding) begin
            s_valid <= 1'b0;
            feeding  = 1'b0;
        end
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // register write on an idle block
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == CFG_PAGE_OFFSET) cur_offset = val;
        else cur_entries = val;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // receiver stall pattern, switching mode when a random timer runs out
    always @(posedge aclk) begin
        if (stall_timer == 0) begin
            stall_mode  = $urandom_range(0, 3);
            stall_timer = $urandom_range(20, 80);
        end else begin
            stall_timer--;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= (stall_timer % 4 == 0);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // result checking and idle tracking
    always @(posedge aclk) begin : result_check
        tlb_result_t want;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (m_valid && m_ready) begin
                if (pending_q.size() == 0) begin
                    $error("result item with nothing expected");
                    fail_count++;
                end else begin
                    want = pending_q.pop_front();
                    if (m_hit !== want.hit) begin
                        $error("hit mismatch: expected %0d, actual %0d", want.hit, m_hit);
                        fail_count++;
                    end
                    if (m_slot !== want.slot) begin
                        $error("slot mismatch: expected %0d, actual %0d", want.slot, m_slot);
                        fail_count++;
                    end
                    if (m_miss_total !== want.misses) begin
                        $error("miss_total mismatch: expected %0d, actual %0d",
                               want.misses, m_miss_total);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any accepted item or taken result
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("testbench failed");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        int                used;
        int                burst_left;
        int                pick;
        bit                steady;
        logic [CFG_W-1:0]  off_val;
        logic [CFG_W-1:0]  use_val;
        logic [ADDR_W-1:0] page;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] low_mask;
        logic [ADDR_W-1:0] hot_pages [$];

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (int i = 0; i < DIR_LEN; i++) begin
            if (DIR_ROWS[i].kind == ROW_CFG) begin
                write_reg(DIR_ROWS[i].reg_idx, DIR_ROWS[i].value[CFG_W-1:0]);
            end else begin
                send_address(DIR_ROWS[i].value, DIR_ROWS[i].known, DIR_ROWS[i].want);
                pause_sender($urandom_range(0, 3));
            end
        end

        // random traces over a hot page set per configuration
        for (int ph = 0; ph < PHASES; ph++) begin
            off_val = CFG_W'(PHASE_OFFSET[ph]);
            use_val = CFG_W'(PHASE_ENTRIES[ph]);
            if (ph == PHASES - 1) begin
                off_val = CFG_W'($urandom_range(0, 31));
                use_val = CFG_W'($urandom_range(0, 31));
            end
            write_reg(CFG_PAGE_OFFSET, off_val);
            write_reg(CFG_ENTRIES_IN_USE, use_val);
            used     = (use_val == 0) ? 1 : ((use_val > SLOTS) ? SLOTS : int'(use_val));
            low_mask = ~({ADDR_W{1'b1}} << off_val);
            hot_pages.delete();
            repeat (used + $urandom_range(0, 4)) hot_pages.push_back($urandom() >> off_val);
            steady     = (ph % 3 == 0);
            burst_left = 0;
            repeat (RANDOM_ITEMS / PHASES) begin
                pick = $urandom_range(0, 99);
                if (pick < 85) begin
                    page = hot_pages[$urandom_range(0, hot_pages.size() - 1)];
                    addr = (page << off_val) | ($urandom() & low_mask);
                end else if (pick < 90) begin
                    // let the hot set drift
                    hot_pages[$urandom_range(0, hot_pages.size() - 1)] = $urandom() >> off_val;
                    addr = $urandom();
                end else begin
                    addr = $urandom();
                end
                send_address(addr, 1'b0, NO_RES);
                if (!steady) begin
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        pause_sender($urandom_range(1, 12));
                    end else begin
                        burst_left--;
                    end
                end
                if ($urandom_range(0, 99) == 0) drain_results();
            end
        end

        drain_results();
        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

>>> fully_assoc_lru_tlb.f
rtl/falt_pkg.sv
rtl/falt_ctrl.sv
rtl/falt_datapath.sv
rtl/fully_assoc_lru_tlb.sv
test/testbench.sv
